// ===== rtl/core/thc_pkg.sv =====
// ---------------------------------------------------------------------------
// thc_pkg: shared types and constants for the tilt / heading block
// Widths, CORDIC arctangent table and the records handed between cells.
// ---------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

  localparam int SW           = 16;          // raw sample width
  localparam int CORDIC_STEPS = 16;          // CORDIC iterations
  localparam int VW           = 24;          // scaled vector width
  localparam int SCALE        = VW - SW;     // sample up-shift
  localparam int XW           = VW + 4;      // CORDIC x / y width, gain headroom
  localparam int ZFRAC        = 16;          // angle fraction bits
  localparam int ZW           = 33;          // angle accumulator width
  localparam int RW           = ZW - ZFRAC;  // rounded angle width
  localparam int TAB_LEN      = 24;
  localparam int STEP_W       = $clog2(TAB_LEN);
  localparam int DW           = 16;          // declination width
  localparam int ROLL_W       = 16;
  localparam int PITCH_W      = 15;
  localparam int HEAD_W       = 16;
  localparam int HW           = 18;          // heading arithmetic width
  localparam int NLANE        = 3;

  localparam int ANG_HALF = 18000;           // 180 deg
  localparam int ANG_QTR  = 9000;            // 90 deg
  localparam int ANG_FULL = 36000;           // 360 deg
  localparam int DECL_RST = -858;            // -8.58 deg

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(longint'(ANG_HALF) * 65536);
  localparam logic signed [ZW-1:0] Z_RND  = ZW'(longint'(1) << (ZFRAC - 1));

  // lane order
  localparam int LN_ROLL  = 0;
  localparam int LN_PITCH = 1;
  localparam int LN_HEAD  = 2;

  typedef struct packed {
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] az;
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] my;
  } smp_t;

  typedef struct packed {
    logic [VW+1:0]   rem;
    logic [VW-1:0]   root;
    logic [2*VW-1:0] rad;
    smp_t            smp;
  } sq_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 spc;   // fixed answer, bypasses the rotation
    logic signed [RW-1:0] sval;
  } lane_t;

  // round(atan(2^-i) * 180/pi * 100 * 2^16)
  function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(294912000);
      5'd1:    v = ZW'(174096719);
      5'd2:    v = ZW'(91987925);
      5'd3:    v = ZW'(46694507);
      5'd4:    v = ZW'(23437865);
      5'd5:    v = ZW'(11730358);
      5'd6:    v = ZW'(5866610);
      5'd7:    v = ZW'(2933484);
      5'd8:    v = ZW'(1466764);
      5'd9:    v = ZW'(733385);
      5'd10:   v = ZW'(366693);
      5'd11:   v = ZW'(183346);
      5'd12:   v = ZW'(91673);
      5'd13:   v = ZW'(45837);
      5'd14:   v = ZW'(22918);
      5'd15:   v = ZW'(11459);
      5'd16:   v = ZW'(5730);
      5'd17:   v = ZW'(2865);
      5'd18:   v = ZW'(1432);
      5'd19:   v = ZW'(716);
      5'd20:   v = ZW'(358);
      5'd21:   v = ZW'(179);
      5'd22:   v = ZW'(90);
      5'd23:   v = ZW'(45);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/thc_ifs.sv =====
// ---------------------------------------------------------------------------
// thc_ifs: request channels of the tilt / heading block
// Sample, result and declination write channels, valid/ready each.
// ---------------------------------------------------------------------------
`default_nettype none

interface thc_sample_if;
  logic                          valid;
  logic                          ready;
  logic signed [thc_pkg::SW-1:0] accel_x;
  logic signed [thc_pkg::SW-1:0] accel_y;
  logic signed [thc_pkg::SW-1:0] accel_z;
  logic signed [thc_pkg::SW-1:0] mag_x;
  logic signed [thc_pkg::SW-1:0] mag_y;
  modport source (output valid, accel_x, accel_y, accel_z, mag_x, mag_y, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, mag_x, mag_y, output ready);
endinterface

interface thc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [thc_pkg::ROLL_W-1:0]  roll_angle;
  logic signed [thc_pkg::PITCH_W-1:0] pitch_angle;
  logic        [thc_pkg::HEAD_W-1:0]  heading_angle;
  modport source (output valid, roll_angle, pitch_angle, heading_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, heading_angle, output ready);
endinterface

interface thc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic signed [thc_pkg::DW-1:0] declination;
  modport source (output valid, declination, input ready);
  modport sink   (input valid, declination, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tilt_heading_from_accel_mag.sv =====
// Throughput: one sample per cycle unless a waiting result holds a valid
// item in the last stage. The pipeline is 2 squaring stages, 24 square-root
// cells (one root bit each), 1 set-up stage, 16 CORDIC cells and 1 rounding
// stage ahead of the output register.
// Reset: clears every stage valid bit and the output valid; declination
// returns to -8.58 deg. No clearing pass, ready straight out of reset.
// ---------------------------------------------------------------------------
// tilt_heading_from_accel_mag: roll, pitch and compass heading
// Pipelined isqrt and three CORDIC vectoring lanes, one sample per clock unless the output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tilt_heading_from_accel_mag (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  thc_sample_if.sink smp_i,
  thc_cfg_if.sink    cfg_i,
  thc_result_if.source res_o
);

  localparam int SW    = thc_pkg::SW;
  localparam int VW    = thc_pkg::VW;
  localparam int XW    = thc_pkg::XW;
  localparam int ZW    = thc_pkg::ZW;
  localparam int RW    = thc_pkg::RW;
  localparam int HW    = thc_pkg::HW;
  localparam int CS    = thc_pkg::CORDIC_STEPS;
  localparam int NL    = thc_pkg::NLANE;
  // stage map: mult, sum, sqrt cells, set-up, cordic cells, round
  localparam int ST_RND  = VW + 3 + CS;
  localparam int NST     = ST_RND + 1;

  // -------------------------------------------------------------------------
  // Flow control. The whole row moves together; it also moves when the last
  // stage holds a bubble, so bubbles ahead of a waiting result are squeezed
  // out. Once a valid item sits in the last stage behind a waiting result,
  // the row and the input stall.
  // -------------------------------------------------------------------------
  logic           en;
  logic           in_fire;
  logic [NST-1:0] vld_q;
  logic           out_vld_q;

  assign en          = res_o.ready | ~out_vld_q | ~vld_q[NST-1];
  assign smp_i.ready = en;
  assign in_fire     = smp_i.valid & en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NST-2:0], in_fire};
      end
      out_vld_q <= (out_vld_q & ~res_o.ready) | (en & vld_q[NST-1]);
    end
  end

  // -------------------------------------------------------------------------
  // Declination register, always writable
  // -------------------------------------------------------------------------
  logic signed [thc_pkg::DW-1:0] decl_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= thc_pkg::DW'(thc_pkg::DECL_RST);
    end else if (cfg_i.valid) begin
      decl_q <= cfg_i.declination;
    end
  end

  // -------------------------------------------------------------------------
  // Squares of ay and az, then their sum (unscaled; scaling is a plain shift)
  // -------------------------------------------------------------------------
  thc_pkg::smp_t          smp_in, smp0_q, smp1_q;
  logic signed [2*SW-1:0] sqy_q, sqz_q;
  logic [2*SW-1:0]        sum_q;

  assign smp_in = '{ax: smp_i.accel_x, ay: smp_i.accel_y, az: smp_i.accel_z,
                    mx: smp_i.mag_x,   my: smp_i.mag_y};

  always_ff @(posedge clk_i) begin
    if (en) begin
      smp0_q <= smp_in;
      sqy_q  <= smp_i.accel_y * smp_i.accel_y;
      sqz_q  <= smp_i.accel_z * smp_i.accel_z;
      smp1_q <= smp0_q;
      sum_q  <= sqy_q + sqz_q;   // both non-negative, sum fits unsigned
    end
  end

  // -------------------------------------------------------------------------
  // Square-root row: one root bit per cell
  // -------------------------------------------------------------------------
  thc_pkg::sq_t sq [VW+1];

  assign sq[0] = '{rem: '0, root: '0,
                   rad: (2*VW)'(sum_q) << (2*thc_pkg::SCALE), smp: smp1_q};

  for (genvar k = 0; k < VW; k++) begin : g_sqrt
    thc_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq[k]),
      .sq_o  (sq[k+1])
    );
  end

  // -------------------------------------------------------------------------
  // Lane set-up: quadrant fold and the axis cases with a fixed answer
  // -------------------------------------------------------------------------
  function automatic thc_pkg::lane_t lane_init(input logic signed [XW-1:0] y,
                                               input logic signed [XW-1:0] x);
    thc_pkg::lane_t l;
    l      = '{x: x, y: y, z: '0, spc: 1'b0, sval: '0};
    if (y == 0) begin
      l.spc  = 1'b1;
      l.sval = (x < 0) ? RW'(thc_pkg::ANG_HALF) : '0;
    end else if (x == 0) begin
      l.spc  = 1'b1;
      l.sval = (y > 0) ? RW'(thc_pkg::ANG_QTR) : RW'(-thc_pkg::ANG_QTR);
    end else if (x < 0) begin
      l.z = (y > 0) ? thc_pkg::Z_HALF : -thc_pkg::Z_HALF;
      l.x = -x;
      l.y = -y;
    end
    return l;
  endfunction

  logic signed [XW-1:0] ax_s, ay_s, az_s, mx_s, my_s, mag_s;
  thc_pkg::lane_t       head_init;
  thc_pkg::lane_t       lane0_q [NL];

  always_comb begin
    ax_s  = XW'(sq[VW].smp.ax) <<< thc_pkg::SCALE;
    ay_s  = XW'(sq[VW].smp.ay) <<< thc_pkg::SCALE;
    az_s  = XW'(sq[VW].smp.az) <<< thc_pkg::SCALE;
    mx_s  = XW'(sq[VW].smp.mx) <<< thc_pkg::SCALE;
    my_s  = XW'(sq[VW].smp.my) <<< thc_pkg::SCALE;
    mag_s = XW'({1'b0, sq[VW].root});
    // heading with mag_x zero is pinned to the y axis sign
    if (mx_s == 0) begin
      head_init      = '{x: '0, y: '0, z: '0, spc: 1'b1, sval: '0};
      head_init.sval = (my_s > 0) ? RW'(thc_pkg::ANG_HALF) : '0;
    end else begin
      head_init = lane_init(-my_s, -mx_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane0_q[thc_pkg::LN_ROLL]  <= lane_init(ay_s, az_s);
      lane0_q[thc_pkg::LN_PITCH] <= lane_init(-ax_s, mag_s);
      lane0_q[thc_pkg::LN_HEAD]  <= head_init;
    end
  end

  // -------------------------------------------------------------------------
  // CORDIC row: three lanes side by side, one micro-rotation per cell
  // -------------------------------------------------------------------------
  thc_pkg::lane_t cord [CS][NL];

  for (genvar s = 0; s < CS; s++) begin : g_step
    for (genvar l = 0; l < NL; l++) begin : g_lane
      if (s == 0) begin : g_first
        thc_cordic_cell u_cell (
          .clk_i  (clk_i),
          .en_i   (en),
          .step_i (thc_pkg::STEP_W'(s)),
          .lane_i (lane0_q[l]),
          .lane_o (cord[s][l])
        );
      end else begin : g_next
        thc_cordic_cell u_cell (
          .clk_i  (clk_i),
          .en_i   (en),
          .step_i (thc_pkg::STEP_W'(s)),
          .lane_i (cord[s-1][l]),
          .lane_o (cord[s][l])
        );
      end
    end
  end

  // -------------------------------------------------------------------------
  // Round half up to hundredths of a degree
  // -------------------------------------------------------------------------
  logic signed [ZW-1:0] zr [NL];
  logic signed [RW-1:0] rnd_q [NL];

  for (genvar l = 0; l < NL; l++) begin : g_rnd
    assign zr[l] = cord[CS-1][l].z + thc_pkg::Z_RND;
    always_ff @(posedge clk_i) begin
      if (en) begin
        rnd_q[l] <= cord[CS-1][l].spc ? cord[CS-1][l].sval
                                       : zr[l][ZW-1:thc_pkg::ZFRAC];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Clamp tilt, subtract declination, wrap heading into one turn
  // -------------------------------------------------------------------------
  logic signed [RW-1:0] roll_c, pitch_c;
  logic signed [HW-1:0] hd, hw;

  always_comb begin
    roll_c = rnd_q[thc_pkg::LN_ROLL];
    if (roll_c > thc_pkg::ANG_HALF) begin
      roll_c = RW'(thc_pkg::ANG_HALF);
    end else if (roll_c < -thc_pkg::ANG_HALF) begin
      roll_c = RW'(-thc_pkg::ANG_HALF);
    end
    pitch_c = rnd_q[thc_pkg::LN_PITCH];
    if (pitch_c > thc_pkg::ANG_QTR) begin
      pitch_c = RW'(thc_pkg::ANG_QTR);
    end else if (pitch_c < -thc_pkg::ANG_QTR) begin
      pitch_c = RW'(-thc_pkg::ANG_QTR);
    end
    hd = HW'(rnd_q[thc_pkg::LN_HEAD]) - HW'(decl_q);
    if (hd >= thc_pkg::ANG_FULL) begin
      hw = hd - HW'(thc_pkg::ANG_FULL);
    end else if (hd < -thc_pkg::ANG_FULL) begin
      hw = hd + HW'(2 * thc_pkg::ANG_FULL);
    end else if (hd < 0) begin
      hw = hd + HW'(thc_pkg::ANG_FULL);
    end else begin
      hw = hd;
    end
  end

  logic signed [thc_pkg::ROLL_W-1:0]  roll_q;
  logic signed [thc_pkg::PITCH_W-1:0] pitch_q;
  logic        [thc_pkg::HEAD_W-1:0]  head_q;

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      roll_q  <= thc_pkg::ROLL_W'(roll_c);
      pitch_q <= thc_pkg::PITCH_W'(pitch_c);
      head_q  <= thc_pkg::HEAD_W'(hw);
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.roll_angle    = roll_q;
  assign res_o.pitch_angle   = pitch_q;
  assign res_o.heading_angle = head_q;

endmodule

`default_nettype wire

// ===== rtl/core/thc_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// thc_sqrt_cell: one root bit of a restoring square root
// Takes two radicand bits, decides one root bit, carries the sample along.
// ---------------------------------------------------------------------------
`default_nettype none

module thc_sqrt_cell (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire thc_pkg::sq_t sq_i,
  output thc_pkg::sq_t     sq_o
);

  localparam int VW = thc_pkg::VW;

  logic [VW+1:0] rem_sh, trial;
  thc_pkg::sq_t  sq_d, sq_q;

  always_comb begin
    rem_sh = {sq_i.rem[VW-1:0], sq_i.rad[2*VW-1 -: 2]};
    trial  = {sq_i.root, 2'b01};
    sq_d     = sq_i;
    sq_d.rad = sq_i.rad << 2;
    if (rem_sh >= trial) begin
      sq_d.rem  = rem_sh - trial;
      sq_d.root = {sq_i.root[VW-2:0], 1'b1};
    end else begin
      sq_d.rem  = rem_sh;
      sq_d.root = {sq_i.root[VW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

// ===== rtl/core/thc_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// thc_cordic_cell: one vectoring CORDIC micro-rotation
// Drives y towards zero and accumulates the angle for one lane.
// ---------------------------------------------------------------------------
`default_nettype none

module thc_cordic_cell (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [thc_pkg::STEP_W-1:0]  step_i,
  input  wire thc_pkg::lane_t              lane_i,
  output thc_pkg::lane_t                   lane_o
);

  logic signed [thc_pkg::XW-1:0] xs, ys;
  thc_pkg::lane_t                lane_d, lane_q;

  always_comb begin
    xs     = lane_i.x >>> step_i;   // floor shift
    ys     = lane_i.y >>> step_i;
    lane_d = lane_i;
    if (lane_i.y > 0) begin
      lane_d.x = lane_i.x + ys;
      lane_d.y = lane_i.y - xs;
      lane_d.z = lane_i.z + thc_pkg::atan_entry(step_i);
    end else begin
      lane_d.x = lane_i.x - ys;
      lane_d.y = lane_i.y + xs;
      lane_d.z = lane_i.z - thc_pkg::atan_entry(step_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire
